// ----- design/cbm_pkg.sv -----
// Package for the cartridge bank mapper: field widths, opcodes, bus port codes,
// configuration register indexes and reset values.
// No dependencies; used by the channel interfaces and the top level.
package cbm_pkg;

  localparam int OpcodeW  = 2;
  localparam int AddrW    = 16;
  localparam int DataW    = 8;
  localparam int OffsetW  = 21;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int BankW    = 8;
  localparam int SelW     = 3;

  // Input opcodes
  typedef enum logic [OpcodeW-1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_PRG_READ  = 2'd1,
    OP_CHR_READ  = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_t;

  // CPU write decode
  localparam logic [AddrW-1:0] PORT_MASK        = 16'hE001;
  localparam logic [AddrW-1:0] PORT_BANK_SELECT = 16'h8000;
  localparam logic [AddrW-1:0] PORT_BANK_DATA   = 16'h8001;
  localparam logic [AddrW-1:0] PORT_MIRROR      = 16'hA000;

  // PRG bank 6 fold
  localparam logic [DataW-1:0] PRG_FOLD_LIMIT = 8'h50;
  localparam logic [DataW-1:0] PRG_FOLD_MASK  = 8'h4F;

  // Bank select codes
  localparam logic [SelW-1:0] SEL_PRG_R6 = 3'd6;
  localparam logic [SelW-1:0] SEL_PRG_R7 = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_BANK_MASK = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHR_PRESENT   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_SCREEN   = 2'd3;

  // Reset values
  localparam logic [BankW-1:0] PRG_MASK_RST = 8'd15;
  localparam logic [BankW-1:0] CHR_MASK_RST = 8'd127;

  typedef logic [BankW-1:0] bank_t;

endpackage

// ----- design/cbm_in_if.sv -----
// Input channel of the cartridge bank mapper: one bus access per item.
// Depends on cbm_pkg for field widths.
interface cbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::OpcodeW-1:0] opcode;
  logic [cbm_pkg::AddrW-1:0]   bus_address;
  logic [cbm_pkg::DataW-1:0]   write_data;

  modport source (output valid, output opcode, output bus_address, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input bus_address, input write_data,
                output ready);
endinterface

// ----- design/cbm_out_if.sv -----
// Result channel of the cartridge bank mapper: one translation result per item.
// Depends on cbm_pkg for field widths.
interface cbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::OffsetW-1:0] mapped_offset;
  logic                        offset_valid;
  logic                        nt_mirror;

  modport source (output valid, output mapped_offset, output offset_valid,
                  output nt_mirror, input ready);
  modport sink (input valid, input mapped_offset, input offset_valid,
                input nt_mirror, output ready);
endinterface

// ----- design/cbm_cfg_if.sv -----
// Configuration write channel of the cartridge bank mapper.
// Depends on cbm_pkg for index and data widths.
interface cbm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cbm_pkg::CfgIdxW-1:0]  index;
  logic [cbm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/cartridge_bank_mapper.sv -----
// Cartridge bank mapper: CPU bank register writes, PRG and CHR address translation.
// Items pass in order through the input register and then the result register. One item per cycle
// sustained, limited only by the result register being taken. Synchronous active-low reset restores
// the bank registers, modes, mirroring and configuration to defaults. Configuration writes are
// always ready, effective next cycle.
// Depends on cbm_pkg, cbm_in_if, cbm_out_if, cbm_cfg_if.
module cartridge_bank_mapper (
  input  logic      clk,
  input  logic      rst_n,
  cbm_in_if.sink    in_chan,
  cbm_out_if.source out_chan,
  cbm_cfg_if.sink   cfg_chan
);

  // Configuration registers
  cbm_pkg::bank_t prg_mask_r;
  cbm_pkg::bank_t chr_mask_r;
  logic           chr_present_r;
  logic           four_screen_r;

  // Mapper state
  logic [cbm_pkg::SelW-1:0] bank_sel_r, bank_sel_nxt;
  logic                     prg_swap_r, prg_swap_nxt;
  logic                     chr_swap_r, chr_swap_nxt;
  cbm_pkg::bank_t           chr_bank_r [6];
  cbm_pkg::bank_t           chr_bank_nxt [6];
  cbm_pkg::bank_t           prg_bank_r [2];
  cbm_pkg::bank_t           prg_bank_nxt [2];
  logic                     mirror_r, mirror_nxt;

  // Input register stage
  logic                        s1_valid_r;
  logic [cbm_pkg::OpcodeW-1:0] s1_opcode_r;
  logic [cbm_pkg::AddrW-1:0]   s1_addr_r;
  logic [cbm_pkg::DataW-1:0]   s1_data_r;

  // Result register stage
  logic                        out_valid_r;
  logic [cbm_pkg::OffsetW-1:0] out_offset_r, out_offset_nxt;
  logic                        out_ovalid_r, out_ovalid_nxt;
  logic                        out_mirror_r;

  logic s2_fire;
  logic in_fire;

  assign s2_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s2_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.mapped_offset = out_offset_r;
  assign out_chan.offset_valid  = out_ovalid_r;
  assign out_chan.nt_mirror     = out_mirror_r;

  // Translation datapath
  logic [cbm_pkg::AddrW-1:0] port_addr;
  logic [1:0]                prg_slot;
  cbm_pkg::bank_t            second_last;
  cbm_pkg::bank_t            prg_bank;
  logic                      chr_in_2k;
  logic [2:0]                chr_idx;
  cbm_pkg::bank_t            chr_bank_raw;
  cbm_pkg::bank_t            chr_bank;
  cbm_pkg::bank_t            fold_data;

  always_comb begin
    port_addr   = s1_addr_r & cbm_pkg::PORT_MASK;
    prg_slot    = s1_addr_r[14:13];
    second_last = (prg_mask_r - 8'd1) & prg_mask_r;

    // PRG slot select
    case (prg_slot)
      2'd0:    prg_bank = prg_swap_r ? second_last : prg_bank_r[0];
      2'd1:    prg_bank = prg_bank_r[1];
      2'd2:    prg_bank = prg_swap_r ? prg_bank_r[0] : second_last;
      default: prg_bank = prg_mask_r;
    endcase
    prg_bank = prg_bank & prg_mask_r;

    // CHR slot select: one entry read, 2K or 1K layout
    chr_in_2k    = (s1_addr_r[12] == chr_swap_r);
    chr_idx      = chr_in_2k ? {2'b00, s1_addr_r[11]} : (3'd2 + {1'b0, s1_addr_r[11:10]});
    chr_bank_raw = chr_bank_r[chr_idx];
    chr_bank     = chr_in_2k ? (chr_bank_raw & {1'b0, chr_mask_r[7:1]})
                             : (chr_bank_raw & chr_mask_r);

    fold_data = (s1_data_r >= cbm_pkg::PRG_FOLD_LIMIT) ? (s1_data_r & cbm_pkg::PRG_FOLD_MASK)
                                                      : s1_data_r;

    bank_sel_nxt = bank_sel_r;
    prg_swap_nxt = prg_swap_r;
    chr_swap_nxt = chr_swap_r;
    chr_bank_nxt = chr_bank_r;
    prg_bank_nxt = prg_bank_r;
    mirror_nxt   = mirror_r;
    out_offset_nxt = '0;
    out_ovalid_nxt = 1'b0;

    case (cbm_pkg::opcode_t'(s1_opcode_r))
      cbm_pkg::OP_CPU_WRITE: begin
        if (port_addr == cbm_pkg::PORT_BANK_SELECT) begin
          bank_sel_nxt = s1_data_r[2:0];
          prg_swap_nxt = s1_data_r[6];
          chr_swap_nxt = s1_data_r[7];
        end else if (port_addr == cbm_pkg::PORT_BANK_DATA) begin
          if (bank_sel_r <= 3'd1) begin
            chr_bank_nxt[bank_sel_r] = {1'b0, s1_data_r[7:1]};
          end else if (bank_sel_r <= 3'd5) begin
            chr_bank_nxt[bank_sel_r] = s1_data_r;
          end else if (bank_sel_r == cbm_pkg::SEL_PRG_R6) begin
            prg_bank_nxt[0] = fold_data;
          end else begin
            prg_bank_nxt[1] = s1_data_r;
          end
        end else if (port_addr == cbm_pkg::PORT_MIRROR) begin
          if (!four_screen_r) begin
            mirror_nxt = s1_data_r[0];
          end
        end
      end
      cbm_pkg::OP_PRG_READ: begin
        if (s1_addr_r[15]) begin
          out_offset_nxt = {prg_bank, s1_addr_r[12:0]};
          out_ovalid_nxt = 1'b1;
        end
      end
      cbm_pkg::OP_CHR_READ: begin
        if (s1_addr_r[15:13] == 3'd0 && chr_present_r) begin
          out_offset_nxt = chr_in_2k ? {3'b000, chr_bank[6:0], s1_addr_r[10:0]}
                                     : {3'b000, chr_bank, s1_addr_r[9:0]};
          out_ovalid_nxt = 1'b1;
        end
      end
      default: begin
        out_ovalid_nxt = 1'b0;
      end
    endcase
  end

  // Control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      prg_mask_r    <= cbm_pkg::PRG_MASK_RST;
      chr_mask_r    <= cbm_pkg::CHR_MASK_RST;
      chr_present_r <= 1'b1;
      four_screen_r <= 1'b0;
      bank_sel_r    <= '0;
      prg_swap_r    <= 1'b0;
      chr_swap_r    <= 1'b0;
      chr_bank_r[0] <= 8'd0;
      chr_bank_r[1] <= 8'd1;
      chr_bank_r[2] <= 8'd4;
      chr_bank_r[3] <= 8'd5;
      chr_bank_r[4] <= 8'd6;
      chr_bank_r[5] <= 8'd7;
      prg_bank_r[0] <= 8'd0;
      prg_bank_r[1] <= 8'd1;
      mirror_r      <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s2_fire) begin
        out_valid_r <= 1'b1;
        bank_sel_r  <= bank_sel_nxt;
        prg_swap_r  <= prg_swap_nxt;
        chr_swap_r  <= chr_swap_nxt;
        chr_bank_r  <= chr_bank_nxt;
        prg_bank_r  <= prg_bank_nxt;
        mirror_r    <= mirror_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // configuration writes
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          cbm_pkg::CFG_PRG_BANK_MASK: prg_mask_r    <= cfg_chan.data;
          cbm_pkg::CFG_CHR_BANK_MASK: chr_mask_r    <= cfg_chan.data;
          cbm_pkg::CFG_CHR_PRESENT:   chr_present_r <= cfg_chan.data[0];
          cbm_pkg::CFG_FOUR_SCREEN:   four_screen_r <= cfg_chan.data[0];
          default:                    chr_present_r <= chr_present_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_chan.opcode;
      s1_addr_r   <= in_chan.bus_address;
      s1_data_r   <= in_chan.write_data;
    end
    if (s2_fire) begin
      out_offset_r <= out_offset_nxt;
      out_ovalid_r <= out_ovalid_nxt;
      out_mirror_r <= mirror_nxt;
    end
  end

endmodule
